/* rtl/core/sdft_pkg.sv */
// package for the sliding dft rms meter: sizes, formats, twiddle tables,
// sequencer states and the rounding helper; no dependencies
package sdft_pkg;

    localparam int WINDOW      = 64;
    localparam int BINS        = 4;
    localparam int SAMPLE_BITS = 16;

    localparam int NOUT   = 4;
    localparam int IN_W   = 16;
    localparam int OUT_W  = 16;
    localparam int POS_W  = $clog2(WINDOW);
    localparam int BIN_W  = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int NMAG   = (BINS > NOUT) ? BINS : NOUT;
    localparam int MAG_W  = $clog2(NMAG);
    localparam int ERR_W  = SAMPLE_BITS + 1;
    localparam int ACC_W  = 32;
    localparam int TW_W   = 19;
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SQ_W   = 64;
    localparam int ROOT_W = 32;
    localparam int Y_W    = PROD_W - 25;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam logic signed [MUL_W-1:0] SQRT2_Q17 = MUL_W'(185364);

    typedef logic signed [TW_W-1:0] t_tw;
    typedef t_tw t_tw_tab [BINS];

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
        S_ROOT, S_SCALE, S_DIV, S_DONE
    } t_state;

    // unsigned long division for the table setup
    function automatic longint unsigned cdiv(input longint unsigned a,
                                             input longint unsigned b);
        longint unsigned q, r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], a[i]};
            if (r >= b) begin
                r = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // twiddles in q1.17, from a q30 taylor series on the quadrant angle
    function automatic t_tw_tab tw_table(input bit want_sin);
        t_tw_tab tab;
        longint unsigned x, x2, st, ct, q, r, n, a4;
        longint s, c, sr, cr, v;
        for (int k = 0; k < BINS; k++) begin
            a4 = 64'(4 * k);
            q  = cdiv(a4, 64'(WINDOW)) & 3;
            r  = a4 - cdiv(a4, 64'(WINDOW)) * 64'(WINDOW);
            x  = cdiv(HALF_PI_Q30 * r, 64'(WINDOW));
            x2 = (x * x + (64'd1 << 29)) >> 30;
            st = x;
            ct = ONE_Q30;
            s  = longint'(x);
            c  = longint'(ONE_Q30);
            for (n = 1; n <= 10; n++) begin
                st = cdiv((st * x2) >> 30, (2 * n) * (2 * n + 1));
                ct = cdiv((ct * x2) >> 30, (2 * n - 1) * (2 * n));
                if (n[0]) begin
                    s = s - longint'(st);
                    c = c - longint'(ct);
                end else begin
                    s = s + longint'(st);
                    c = c + longint'(ct);
                end
            end
            if (s < 0) s = 0;
            if (c < 0) c = 0;
            sr = (s + (64'sd1 <<< 12)) >>> 13;
            cr = (c + (64'sd1 <<< 12)) >>> 13;
            case (q)
                0: v = want_sin ? sr : cr;
                1: v = want_sin ? cr : -sr;
                2: v = want_sin ? -sr : -cr;
                default: v = want_sin ? -cr : sr;
            endcase
            tab[k] = TW_W'(v);
        end
        return tab;
    endfunction

    localparam t_tw_tab TW_COS = tw_table(1'b0);
    localparam t_tw_tab TW_SIN = tw_table(1'b1);

    // floor(x / 2^17 + 1/2), saturated to signed 32 bit
    function automatic logic signed [ACC_W-1:0] round_sat(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] q;
        y = x + SUM_W'(65536);
        q = y >>> 17;
        if ((&q[SUM_W-1:ACC_W-1]) || !(|q[SUM_W-1:ACC_W-1])) begin
            return q[ACC_W-1:0];
        end else if (q[SUM_W-1]) begin
            return {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            return {1'b0, {(ACC_W-1){1'b1}}};
        end
    endfunction

endpackage

/* rtl/core/sdft_ram.sv */
// generic single-port ram with registered read
// no dependencies
module sdft_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

/* rtl/core/sdft_mul.sv */
// shared signed multiplier with registered product
// uses sdft_pkg
module sdft_mul (
    input  logic                                 i_clk,
    input  logic signed [sdft_pkg::MUL_W-1:0]    i_a,
    input  logic signed [sdft_pkg::MUL_W-1:0]    i_b,
    output logic signed [sdft_pkg::PROD_W-1:0]   o_p
);
    import sdft_pkg::*;

    always_ff @(posedge i_clk) begin
        o_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

endmodule

/* rtl/core/sdft_root.sv */
// iterative integer square root, one result bit per cycle
// uses sdft_pkg
module sdft_root (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sdft_pkg::SQ_W-1:0]     i_value,
    output logic                          o_done,
    output logic [sdft_pkg::ROOT_W-1:0]   o_root
);
    import sdft_pkg::*;

    logic [SQ_W-1:0] r_v, n_v;
    logic [SQ_W-1:0] r_res, n_res;
    logic [SQ_W-1:0] r_bit, n_bit;
    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [SQ_W-1:0] trial;

    always_comb begin
        trial  = r_res + r_bit;
        n_v    = r_v;
        n_res  = r_res;
        n_bit  = r_bit;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_v    = i_value;
            n_res  = '0;
            n_bit  = SQ_W'(1) << (SQ_W - 2);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_v >= trial) begin
                n_v   = r_v - trial;
                n_res = (r_res >> 1) + r_bit;
            end else begin
                n_res = r_res >> 1;
            end
            n_bit = r_bit >> 2;
            if (r_bit[0] || r_bit[1]) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_v   <= n_v;
        r_res <= n_res;
        r_bit <= n_bit;
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

/* rtl/core/sliding_dft_four_bin_rms.sv */
// top level of the sliding dft rms meter: sequencer, accumulators, scaling
// multiply; uses sdft_pkg, sdft_ram, sdft_mul, sdft_root
//
// usage
//   one signed sample word enters on i_sample with i_valid; it is taken at a
//   clock edge where i_valid is high and o_stall is low. one result word of
//   four rms magnitudes leaves on o_mag_bin0..3 with o_valid; it is taken at
//   an edge where o_valid is high and i_stall is low.
//   the block works on one sample at a time and holds o_stall high meanwhile.
//   each sample takes an accept step and a history read and write step, then,
//   per bin, the multiply states S_M1 to S_M7, the bit-serial square root, a
//   scaling step and a reciprocal multiply (skipped when the bin saturates),
//   and finally a step that hands the word to the output register.
//   the output register parts the two sides: a new sample is accepted while a
//   finished word still waits; if the receiver still stalls when the next
//   word is finished, the sequencer waits holding it.
//   reset clears the delay line (through a fill flag), the accumulators, the
//   write position and the output valid flag; no clearing pass is needed.
module sliding_dft_four_bin_rms (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [sdft_pkg::IN_W-1:0]    i_sample,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [sdft_pkg::OUT_W-1:0]   o_mag_bin0,
    output logic [sdft_pkg::OUT_W-1:0]   o_mag_bin1,
    output logic [sdft_pkg::OUT_W-1:0]   o_mag_bin2,
    output logic [sdft_pkg::OUT_W-1:0]   o_mag_bin3
);
    import sdft_pkg::*;

    localparam logic [Y_W-1:0] SAT_LIM = Y_W'(WINDOW) << OUT_W;

    // exact division of an unsaturated y by the window through a reciprocal
    localparam int DIV_L = $clog2(WINDOW);
    localparam int DIV_N = DIV_L + OUT_W;
    localparam int DIV_S = DIV_N + DIV_L;
    localparam logic signed [MUL_W-1:0] RECIP =
        MUL_W'(((64'd1 << DIV_S) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    // sequencer and per-sample registers
    t_state                    r_state, n_state;
    logic [POS_W-1:0]          r_pos, n_pos;
    logic                      r_full, n_full;
    logic [BIN_W-1:0]          r_bin, n_bin;
    logic signed [SAMPLE_BITS-1:0] r_smp, n_smp;
    logic signed [ERR_W-1:0]   r_err, n_err;
    logic signed [PROD_W-1:0]  r_sum, n_sum;
    logic signed [ACC_W-1:0]   r_re, n_re;
    logic signed [ACC_W-1:0]   r_im, n_im;

    // accumulators and finished magnitudes
    logic signed [ACC_W-1:0]   r_acc_re [BINS];
    logic signed [ACC_W-1:0]   r_acc_im [BINS];
    logic [OUT_W-1:0]          r_mag [NMAG];
    logic                      r_out_valid, n_out_valid;
    logic [OUT_W-1:0]          r_out [NOUT];

    // datapath wires
    logic [SAMPLE_BITS-1:0]    ram_rdata;
    logic                      ram_we;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic                      root_start, root_done;
    logic [ROOT_W-1:0]         root;
    logic signed [MUL_W-1:0]   tw_c, tw_s, t_val, ai_val, abs_re, abs_im;
    logic signed [SUM_W-1:0]   sq_sum;
    logic signed [PROD_W-1:0]  scale_sum;
    logic [Y_W-1:0]            y_val;
    logic signed [SAMPLE_BITS-1:0] old_smp;
    logic                      acc_we;
    logic                      mag_we;
    logic [OUT_W-1:0]          mag_val;
    logic                      out_load;
    logic                      bin_last;

    sdft_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (r_pos),
        .i_wdata (r_smp),
        .o_rdata (ram_rdata)
    );

    sdft_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    sdft_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_value (sq_sum[SQ_W-1:0]),
        .o_done  (root_done),
        .o_root  (root)
    );

    // operands of the current bin
    assign tw_c   = MUL_W'(TW_COS[r_bin]);
    assign tw_s   = MUL_W'(TW_SIN[r_bin]);
    assign t_val  = MUL_W'(r_acc_re[r_bin]) + (MUL_W'(r_err) <<< 8);
    assign ai_val = MUL_W'(r_acc_im[r_bin]);
    assign abs_re = r_re[ACC_W-1] ? -MUL_W'(r_re) : MUL_W'(r_re);
    assign abs_im = r_im[ACC_W-1] ? -MUL_W'(r_im) : MUL_W'(r_im);

    // re^2 + im^2 and the rounded window scaling of m * sqrt(2)
    assign sq_sum    = SUM_W'(r_sum) + SUM_W'(prod);
    assign scale_sum = prod + (PROD_W'(WINDOW) <<< 24);
    assign y_val     = scale_sum[PROD_W-1:25];
    assign old_smp   = r_full ? signed'(ram_rdata) : '0;
    assign bin_last  = (r_bin == BIN_W'(BINS - 1));

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_full      = r_full;
        n_bin       = r_bin;
        n_smp       = r_smp;
        n_err       = r_err;
        n_sum       = r_sum;
        n_re        = r_re;
        n_im        = r_im;
        n_out_valid = r_out_valid;
        mul_a       = '0;
        mul_b       = '0;
        ram_we      = 1'b0;
        root_start  = 1'b0;
        acc_we      = 1'b0;
        mag_we      = 1'b0;
        mag_val     = '0;
        out_load    = 1'b0;

        // receiver took the word
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                // history at r_pos is read during this cycle
                if (i_valid) begin
                    n_smp   = signed'(SAMPLE_BITS'(i_sample));
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_err  = ERR_W'(old_smp) - ERR_W'(r_smp);
                ram_we = 1'b1;
                if (r_pos == POS_W'(WINDOW - 1)) begin
                    n_pos  = '0;
                    n_full = 1'b1;
                end else begin
                    n_pos = r_pos + POS_W'(1);
                end
                n_bin   = '0;
                n_state = S_M1;
            end
            S_M1: begin
                mul_a   = tw_c;
                mul_b   = t_val;
                n_state = S_M2;
            end
            S_M2: begin
                n_sum   = prod;
                mul_a   = tw_s;
                mul_b   = ai_val;
                n_state = S_M3;
            end
            S_M3: begin
                n_re    = round_sat(SUM_W'(r_sum) - SUM_W'(prod));
                mul_a   = tw_s;
                mul_b   = t_val;
                n_state = S_M4;
            end
            S_M4: begin
                n_sum   = prod;
                mul_a   = tw_c;
                mul_b   = ai_val;
                n_state = S_M5;
            end
            S_M5: begin
                n_im    = round_sat(SUM_W'(r_sum) + SUM_W'(prod));
                mul_a   = abs_re;
                mul_b   = abs_re;
                n_state = S_M6;
            end
            S_M6: begin
                n_sum   = prod;
                mul_a   = abs_im;
                mul_b   = abs_im;
                n_state = S_M7;
            end
            S_M7: begin
                root_start = 1'b1;
                acc_we     = 1'b1;
                n_state    = S_ROOT;
            end
            S_ROOT: begin
                if (root_done) begin
                    mul_a   = MUL_W'(root);
                    mul_b   = SQRT2_Q17;
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                if (y_val >= SAT_LIM) begin
                    mag_we  = 1'b1;
                    mag_val = '1;
                end else begin
                    // y / window as y * reciprocal, taken from the top bits
                    mul_a   = MUL_W'(y_val[DIV_N-1:0]);
                    mul_b   = RECIP;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                mag_we  = 1'b1;
                mag_val = prod[DIV_S +: OUT_W];
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // bin finished: next bin or hand over
        if (mag_we) begin
            if (bin_last) begin
                n_state = S_DONE;
            end else begin
                n_bin   = r_bin + BIN_W'(1);
                n_state = S_M1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_full      <= 1'b0;
            r_bin       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < BINS; k++) begin
                r_acc_re[k] <= '0;
                r_acc_im[k] <= '0;
            end
            for (int k = 0; k < NMAG; k++) begin
                r_mag[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_full      <= n_full;
            r_bin       <= n_bin;
            r_out_valid <= n_out_valid;
            if (acc_we) begin
                r_acc_re[r_bin] <= r_re;
                r_acc_im[r_bin] <= r_im;
            end
            if (mag_we) begin
                r_mag[MAG_W'(r_bin)] <= mag_val;
            end
        end
        r_smp <= n_smp;
        r_err <= n_err;
        r_sum <= n_sum;
        r_re  <= n_re;
        r_im  <= n_im;
        if (out_load) begin
            for (int k = 0; k < NOUT; k++) begin
                r_out[k] <= r_mag[k];
            end
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_mag_bin0 = r_out[0];
    assign o_mag_bin1 = r_out[1];
    assign o_mag_bin2 = r_out[2];
    assign o_mag_bin3 = r_out[3];

    // an accepted word keeps the input side stalled in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accept");

    // the bin counter stays inside the bin range
    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bin <= BIN_W'(BINS - 1))
        else $error("bin counter out of range");

    // the root unit reports only while the sequencer waits for it
    a_root_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        root_done |-> (r_state == S_ROOT))
        else $error("root result outside root wait");

    // a new output word comes only from the hand-over state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_DONE))
        else $error("output word without hand-over");

endmodule

/* dv/sliding_dft_four_bin_rms_test.sv */
// testbench for the four-bin sliding dft rms meter: a queue-fed driver, a
// random-stall monitor and an in-bench predictor; depends on sdft_pkg and the rtl
`timescale 1ns / 100ps

module sliding_dft_four_bin_rms_test;
    import sdft_pkg::*;

    localparam int N_RANDOM    = 400;
    localparam int LONG_HOLD   = 900;   // cycles of receiver hold-off
    localparam int DRAIN_WAIT  = 300;   // idle cycles after the last word is checked

    typedef struct packed {
        logic [OUT_W-1:0] bin0;
        logic [OUT_W-1:0] bin1;
        logic [OUT_W-1:0] bin2;
        logic [OUT_W-1:0] bin3;
    } t_mags;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic [IN_W-1:0] i_sample = '0;
    logic o_stall, o_valid;
    logic [OUT_W-1:0] o_mag_bin0, o_mag_bin1, o_mag_bin2, o_mag_bin3;

    sliding_dft_four_bin_rms u_top (.*);

    always #1 i_clk = ~i_clk;

    // predictor state: delay line, accumulators, write position, twiddles
    logic signed [IN_W-1:0] delay_line [WINDOW];
    longint acc_re [BINS];
    longint acc_im [BINS];
    int unsigned wr_pos;
    longint cos_q17 [BINS];
    longint sin_q17 [BINS];

    logic [IN_W-1:0] pending_words [$];
    t_mags expected_mags [$];
    int words_sent, words_checked, mismatches;
    bit calm;            // stretch with no idling on either side
    bit hold_done;

    // q30 taylor series on the reduced angle, rounded half up to q17
    function automatic void build_twiddles();
        longint unsigned ang, ang2, sterm, cterm, quad, rem;
        longint sv, cv, sq, cq;
        for (int k = 0; k < BINS; k++) begin
            quad  = ((4 * k) / WINDOW) & 3;
            rem   = (4 * k) % WINDOW;
            ang   = (64'd1686629713 * rem) / WINDOW;
            ang2  = (ang * ang + (64'd1 << 29)) >> 30;
            sterm = ang;
            cterm = 64'd1 << 30;
            sv    = longint'(ang);
            cv    = longint'(64'd1 << 30);
            for (longint unsigned n = 1; n <= 10; n++) begin
                sterm = ((sterm * ang2) >> 30) / ((2 * n) * (2 * n + 1));
                cterm = ((cterm * ang2) >> 30) / ((2 * n - 1) * (2 * n));
                if (n % 2 == 1) begin
                    sv -= longint'(sterm);
                    cv -= longint'(cterm);
                end else begin
                    sv += longint'(sterm);
                    cv += longint'(cterm);
                end
            end
            if (sv < 0) sv = 0;
            if (cv < 0) cv = 0;
            sq = (sv + 4096) >>> 13;
            cq = (cv + 4096) >>> 13;
            case (quad)
                0: begin cos_q17[k] = cq;  sin_q17[k] = sq;  end
                1: begin cos_q17[k] = -sq; sin_q17[k] = cq;  end
                2: begin cos_q17[k] = -cq; sin_q17[k] = -sq; end
                default: begin cos_q17[k] = sq; sin_q17[k] = -cq; end
            endcase
        end
    endfunction

    // round half up out of q17 products, clamp to signed 32 bit
    function automatic longint q17_round_clamp(longint x);
        longint r;
        r = (x + 65536) >>> 17;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // slide the window by one sample and queue the four expected magnitudes
    function automatic void slide_window(logic [IN_W-1:0] word);
        longint smp, diff, t, re, im, are, aim;
        longint unsigned root, mag;
        logic [OUT_W-1:0] mags [NOUT];
        t_mags e;
        smp  = longint'($signed(word[SAMPLE_BITS-1:0]));
        diff = longint'(delay_line[wr_pos % WINDOW]) - smp;
        delay_line[wr_pos % WINDOW] = IN_W'(smp);
        wr_pos = (wr_pos % WINDOW + 1) % WINDOW;
        foreach (mags[k]) mags[k] = '0;
        for (int k = 0; k < BINS; k++) begin
            t   = acc_re[k] + diff * 256;
            re  = q17_round_clamp(cos_q17[k] * t - sin_q17[k] * acc_im[k]);
            im  = q17_round_clamp(sin_q17[k] * t + cos_q17[k] * acc_im[k]);
            are = (re < 0) ? -re : re;
            aim = (im < 0) ? -im : im;
            root = int_sqrt(longint'(are * are) + longint'(aim * aim));
            mag  = (root * 185364 + (longint'(WINDOW) << 24)) / (longint'(WINDOW) << 25);
            if (mag > 65535) mag = 65535;
            acc_re[k] = re;
            acc_im[k] = im;
            if (k < NOUT) mags[k] = OUT_W'(mag);
        end
        e.bin0 = mags[0];
        e.bin1 = mags[1];
        e.bin2 = mags[2];
        e.bin3 = mags[3];
        expected_mags.push_back(e);
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if (calm) return 0;
        case ($urandom_range(9))
            0, 1, 2, 3: return 0;
            4, 5, 6, 7: return $urandom_range(3);
            8:          return $urandom_range(20);
            default:    return $urandom_range(300);
        endcase
    endfunction

    // driver: the prediction happens on the accepting edge
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                slide_window(i_sample);
                words_sent++;
            end
            if (i_valid && o_stall) begin
                // stalled word stays put
            end else if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                i_sample <= pending_words.pop_front();
                i_valid  <= 1'b1;
                gap_left = pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall: random stretches plus one long hold-off so the
    // output register and the sequencer both back up
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!hold_done && words_sent >= 150) begin
            hold_done = 1'b1;
            stall_left = LONG_HOLD;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (calm) begin
            i_stall <= 1'b0;
        end else begin
            case ($urandom_range(9))
                0, 1:    stall_left = $urandom_range(4);
                2:       stall_left = $urandom_range(400);
                default: stall_left = 0;
            endcase
            i_stall <= (stall_left > 0);
        end
    end

    // monitor: compare each taken word with the oldest expectation
    always @(posedge i_clk) begin
        t_mags e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_mags.size() == 0) begin
                $error("result word with nothing expected");
                mismatches++;
            end else begin
                e = expected_mags.pop_front();
                words_checked++;
                if (o_mag_bin0 !== e.bin0) begin
                    $error("mag_bin0 expected %0d got %0d", e.bin0, o_mag_bin0);
                    mismatches++;
                end
                if (o_mag_bin1 !== e.bin1) begin
                    $error("mag_bin1 expected %0d got %0d", e.bin1, o_mag_bin1);
                    mismatches++;
                end
                if (o_mag_bin2 !== e.bin2) begin
                    $error("mag_bin2 expected %0d got %0d", e.bin2, o_mag_bin2);
                    mismatches++;
                end
                if (o_mag_bin3 !== e.bin3) begin
                    $error("mag_bin3 expected %0d got %0d", e.bin3, o_mag_bin3);
                    mismatches++;
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        int amp, period, shape, len;
        foreach (delay_line[i]) delay_line[i] = '0;
        foreach (acc_re[k]) begin
            acc_re[k] = 0;
            acc_im[k] = 0;
        end
        wr_pos = 0;
        build_twiddles();

        // directed: zero, both extremes, +-1, then a full-scale square burst
        pending_words.push_back(16'h0000);
        pending_words.push_back(16'h7fff);
        pending_words.push_back(16'h8000);
        pending_words.push_back(16'h0001);
        pending_words.push_back(16'hffff);
        pending_words.push_back(16'h8000);
        for (int i = 0; i < 18; i++)
            pending_words.push_back((i % 2) ? 16'h7fff : 16'h8000);

        // random: signal-like bursts at the bin frequencies with random
        // amplitude, plus raw noise; bursts are what build up the bins
        while (pending_words.size() < 24 + N_RANDOM) begin
            shape = $urandom_range(3);
            len   = $urandom_range(10, 40);
            amp   = $urandom_range(32767);
            period = WINDOW / $urandom_range(1, 3);
            for (int i = 0; i < len; i++) begin
                case (shape)
                    0: pending_words.push_back(16'($urandom));
                    1: pending_words.push_back(((i % period) < period / 2) ?
                                               16'(amp) : 16'(-amp - 1));
                    2: pending_words.push_back(16'(amp));
                    default: pending_words.push_back(16'($signed($urandom_range(64)) - 32));
                endcase
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one quiet stretch with no idling on either side
        wait (words_sent >= 250);
        calm = 1'b1;
        wait (words_sent >= 300);
        calm = 1'b0;

        wait (pending_words.size() == 0 && !i_valid && expected_mags.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("covered %0d samples with %0d result words checked,", words_sent,
                 words_checked);
        $display("including extremes, bin-frequency bursts and a long output hold-off");
        if (mismatches == 0 && expected_mags.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
